@@ rtl/core/matroska_lacing_decoder_macros.svh @@
// Assertion helpers shared by the lace decoder RTL.
`ifndef MATROSKA_LACING_DECODER_MACROS_SVH
`define MATROSKA_LACING_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MLD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MLD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/mld_pkg.sv @@
`default_nettype none
package mld_pkg;

    localparam int PAYLOAD_W = 32;
    localparam int REPEAT_W  = 9;
    localparam int DIV_STEPS = 32;

    localparam logic [1:0] LACE_NONE  = 2'd0;
    localparam logic [1:0] LACE_XIPH  = 2'd1;
    localparam logic [1:0] LACE_FIXED = 2'd2;
    localparam logic [1:0] LACE_EBML  = 2'd3;

    localparam logic [7:0]  XIPH_RUN   = 8'd255;
    localparam logic [12:0] BIAS_SHORT = 13'h003f;
    localparam logic [12:0] BIAS_LONG  = 13'h1fff;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_CODING   = 2'd1,
        ERR_DIVIDE   = 2'd2,
        ERR_OVERRUN  = 2'd3
    } t_err;

    typedef enum logic [1:0] {
        PH_NONE = 2'd0,
        PH_XIPH = 2'd1,
        PH_EBML = 2'd2
    } t_phase;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK,
        S_XACC,
        S_DECODE,
        S_DADD,
        S_DBIAS,
        S_CMP,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [PAYLOAD_W-1:0] frame_size;
        logic [REPEAT_W-1:0]  repeat_count;
        logic                 final_frame;
        t_err                 error_code;
    } t_result;

    // Length of an EBML varint from its first byte: position of the leading one, 0 if none.
    function automatic logic [3:0] varint_len(input logic [7:0] b);
        logic [3:0] l;
        l = 4'd0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                l = 4'(8 - i);
            end
        end
        return l;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/mld_if.sv @@
`default_nettype none
interface mld_byte_if;
    import mld_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 start_req;
    logic [1:0]           lace_mode;
    logic [PAYLOAD_W-1:0] payload_length;
    logic [7:0]           header_byte;

    modport source (
        output valid, start_req, lace_mode, payload_length, header_byte,
        input  ready
    );
    modport sink (
        input  valid, start_req, lace_mode, payload_length, header_byte,
        output ready
    );
endinterface

interface mld_frame_if;
    import mld_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [PAYLOAD_W-1:0] frame_size;
    logic [REPEAT_W-1:0]  repeat_count;
    logic                 final_frame;
    logic [1:0]           error_code;

    modport source (
        output valid, frame_size, repeat_count, final_frame, error_code,
        input  ready
    );
    modport sink (
        input  valid, frame_size, repeat_count, final_frame, error_code,
        output ready
    );
endinterface
`default_nettype wire

@@ rtl/core/matroska_lacing_decoder.sv @@
// Matroska lace header decoder. Feed one word per header byte: a start word carries the
// frame-count byte, lacing mode and payload length; the following words carry the Xiph or
// EBML size bytes. Results come out as words of frame size, repeat count, a final flag and an
// error code; error-free Xiph and EBML headers end with the rest-of-payload frame. The size, payload and
// divide arithmetic runs on one shared 33-bit adder under a small sequencer, so the block takes
// one word at a time and takes no new word until its result words are delivered. A fixed-lacing
// start runs a restoring divide that retires one quotient bit per cycle on the adder.
`default_nettype none
`include "matroska_lacing_decoder_macros.svh"
module matroska_lacing_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mld_byte_if.sink    i_lace,
    mld_frame_if.source o_frame
);
    import mld_pkg::*;

    t_state        r_state, n_state;
    t_phase        r_phase, n_phase;
    logic          r_first, n_first;
    logic [2:0]    r_vbytes, n_vbytes;
    logic [3:0]    r_vlen, n_vlen;
    logic [7:0]    r_sizes_left, n_sizes_left;
    logic [32:0]   r_payload_left, n_payload_left;
    logic [32:0]   r_acc, n_acc;
    logic          r_big, n_big;
    logic [32:0]   r_prev, n_prev;
    logic [7:0]    r_byte, n_byte;
    logic [7:0]    r_rem, n_rem;
    logic [4:0]    r_cnt, n_cnt;
    logic          r_more, n_more;
    t_result       r_out, n_out;

    logic [32:0]   alu_a, alu_b, alu_res;
    logic          alu_sub, alu_carry;
    logic [33:0]   alu_sum;

    logic [3:0]    vlen_dec;
    logic [32:0]   acc_dec;
    logic          big_dec;
    logic [2:0]    vbytes_dec;
    logic [8:0]    divisor;
    logic [8:0]    trial;
    logic [7:0]    rem_dec;
    logic [31:0]   quot_dec;
    logic [32:0]   bias;
    logic          in_fire, out_fire;

    function automatic t_result fail_word(input t_err e);
        t_result w;
        w.frame_size   = '0;
        w.repeat_count = '0;
        w.final_frame  = 1'b1;
        w.error_code   = e;
        return w;
    endfunction

    assign i_lace.ready         = (r_state == S_IDLE);
    assign o_frame.valid        = (r_state == S_OUT);
    assign o_frame.frame_size   = r_out.frame_size;
    assign o_frame.repeat_count = r_out.repeat_count;
    assign o_frame.final_frame  = r_out.final_frame;
    assign o_frame.error_code   = r_out.error_code;

    assign in_fire  = i_lace.valid && i_lace.ready;
    assign out_fire = o_frame.valid && o_frame.ready;

    // Shared adder: a + b, or a - b with carry high when no borrow.
    assign alu_sum   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + 34'(alu_sub);
    assign alu_res   = alu_sum[32:0];
    assign alu_carry = alu_sum[33];

    assign divisor  = {1'b0, r_sizes_left} + 9'd1;
    assign trial    = {r_rem, r_acc[31]};
    assign rem_dec  = alu_carry ? alu_res[7:0] : trial[7:0];
    assign quot_dec = {r_acc[30:0], alu_carry};
    assign bias     = (r_vlen == 4'd1) ? 33'(BIAS_SHORT) : 33'(BIAS_LONG);
    assign vlen_dec = varint_len(r_byte);

    always_comb begin
        if (r_vbytes == 3'd0) begin
            acc_dec    = {25'd0, r_byte & (8'hff >> vlen_dec)};
            big_dec    = 1'b0;
            vbytes_dec = 3'(vlen_dec - 4'd1);
        end else begin
            // Bits shifted out above 33 only matter as a sticky too-large flag.
            acc_dec    = {r_acc[24:0], r_byte};
            big_dec    = r_big | (|r_acc[32:25]);
            vbytes_dec = r_vbytes - 3'd1;
        end
    end

    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (r_state)
            S_CHK: begin
                alu_a   = r_payload_left;
                alu_b   = 33'd1;
                alu_sub = 1'b1;
            end
            S_XACC: begin
                alu_a = r_acc;
                alu_b = {25'd0, r_byte};
            end
            S_DADD: begin
                alu_a = r_prev;
                alu_b = r_acc;
            end
            S_DBIAS: begin
                alu_a   = r_acc;
                alu_b   = bias;
                alu_sub = 1'b1;
            end
            S_CMP: begin
                alu_a   = r_payload_left;
                alu_b   = r_acc;
                alu_sub = 1'b1;
            end
            S_DIV: begin
                alu_a   = 33'(trial);
                alu_b   = 33'(divisor);
                alu_sub = 1'b1;
            end
            default: begin
                alu_a   = '0;
            end
        endcase
    end

    always_comb begin
        n_state        = r_state;
        n_phase        = r_phase;
        n_first        = r_first;
        n_vbytes       = r_vbytes;
        n_vlen         = r_vlen;
        n_sizes_left   = r_sizes_left;
        n_payload_left = r_payload_left;
        n_acc          = r_acc;
        n_big          = r_big;
        n_prev         = r_prev;
        n_byte         = r_byte;
        n_rem          = r_rem;
        n_cnt          = r_cnt;
        n_more         = r_more;
        n_out          = r_out;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_lace.start_req) begin
                        n_payload_left = {1'b0, i_lace.payload_length};
                        n_sizes_left   = i_lace.header_byte;
                        n_acc          = '0;
                        n_big          = 1'b0;
                        n_vbytes       = '0;
                        n_vlen         = '0;
                        n_prev         = '0;
                        n_first        = 1'b0;
                        n_rem          = '0;
                        n_cnt          = '0;
                        n_more         = 1'b0;
                        n_phase        = PH_NONE;
                        if (i_lace.lace_mode == LACE_FIXED) begin
                            n_acc   = {1'b0, i_lace.payload_length};
                            n_state = S_DIV;
                        end else if (i_lace.lace_mode == LACE_NONE ||
                                     i_lace.header_byte == 8'd0) begin
                            n_out.frame_size   = i_lace.payload_length;
                            n_out.repeat_count = 9'd1;
                            n_out.final_frame  = 1'b1;
                            n_out.error_code   = ERR_NONE;
                            n_state            = S_OUT;
                        end else if (i_lace.lace_mode == LACE_XIPH) begin
                            n_phase = PH_XIPH;
                        end else begin
                            n_phase = PH_EBML;
                            n_first = 1'b1;
                        end
                    end else if (r_phase != PH_NONE) begin
                        n_byte  = i_lace.header_byte;
                        n_state = S_CHK;
                    end
                end
            end
            S_CHK: begin
                // Borrow on the decrement means no payload byte is left.
                if (!alu_carry) begin
                    n_out   = fail_word(ERR_OVERRUN);
                    n_more  = 1'b0;
                    n_phase = PH_NONE;
                    n_state = S_OUT;
                end else begin
                    n_payload_left = alu_res;
                    n_state        = (r_phase == PH_XIPH) ? S_XACC : S_DECODE;
                end
            end
            S_XACC: begin
                n_acc   = alu_res;
                n_big   = r_big | alu_carry;
                n_state = (r_byte == XIPH_RUN) ? S_IDLE : S_CMP;
            end
            S_DECODE: begin
                if (r_vbytes == 3'd0 &&
                    (vlen_dec == 4'd0 || (!r_first && vlen_dec > 4'd2))) begin
                    n_out   = fail_word(ERR_CODING);
                    n_more  = 1'b0;
                    n_phase = PH_NONE;
                    n_state = S_OUT;
                end else begin
                    n_acc    = acc_dec;
                    n_big    = big_dec;
                    n_vbytes = vbytes_dec;
                    if (r_vbytes == 3'd0) begin
                        n_vlen = vlen_dec;
                    end
                    if (vbytes_dec != 3'd0) begin
                        n_state = S_IDLE;
                    end else if (r_first) begin
                        if (big_dec || acc_dec[32]) begin
                            n_out   = fail_word(ERR_CODING);
                            n_more  = 1'b0;
                            n_phase = PH_NONE;
                            n_state = S_OUT;
                        end else begin
                            n_first = 1'b0;
                            n_prev  = acc_dec;
                            n_state = S_CMP;
                        end
                    end else begin
                        n_state = S_DADD;
                    end
                end
            end
            S_DADD: begin
                n_acc   = alu_res;
                n_state = S_DBIAS;
            end
            S_DBIAS: begin
                if (!alu_carry) begin
                    n_out   = fail_word(ERR_CODING);
                    n_more  = 1'b0;
                    n_phase = PH_NONE;
                    n_state = S_OUT;
                end else begin
                    n_acc   = alu_res;
                    n_prev  = alu_res;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (r_big || !alu_carry) begin
                    n_out   = fail_word(ERR_OVERRUN);
                    n_more  = 1'b0;
                    n_phase = PH_NONE;
                    n_state = S_OUT;
                end else begin
                    n_payload_left     = alu_res;
                    n_out.frame_size   = r_acc[31:0];
                    n_out.repeat_count = 9'd1;
                    n_out.final_frame  = 1'b0;
                    n_out.error_code   = ERR_NONE;
                    n_sizes_left       = r_sizes_left - 8'd1;
                    n_acc              = '0;
                    n_big              = 1'b0;
                    n_more             = (r_sizes_left == 8'd1);
                    if (r_sizes_left == 8'd1) begin
                        n_phase = PH_NONE;
                    end
                    n_state = S_OUT;
                end
            end
            S_DIV: begin
                n_rem = rem_dec;
                n_acc = {1'b0, quot_dec};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(DIV_STEPS - 1)) begin
                    if (rem_dec != 8'd0) begin
                        n_out = fail_word(ERR_DIVIDE);
                    end else begin
                        n_out.frame_size   = quot_dec;
                        n_out.repeat_count = divisor;
                        n_out.final_frame  = 1'b1;
                        n_out.error_code   = ERR_NONE;
                    end
                    n_more  = 1'b0;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_fire) begin
                    if (r_more) begin
                        // Rest of the payload is the last frame.
                        n_out.frame_size   = r_payload_left[31:0];
                        n_out.repeat_count = 9'd1;
                        n_out.final_frame  = 1'b1;
                        n_out.error_code   = ERR_NONE;
                        n_more             = 1'b0;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_phase      <= PH_NONE;
            r_first      <= 1'b0;
            r_vbytes     <= '0;
            r_sizes_left <= '0;
            r_cnt        <= '0;
            r_more       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_first      <= n_first;
            r_vbytes     <= n_vbytes;
            r_sizes_left <= n_sizes_left;
            r_cnt        <= n_cnt;
            r_more       <= n_more;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vlen         <= n_vlen;
        r_payload_left <= n_payload_left;
        r_acc          <= n_acc;
        r_big          <= n_big;
        r_prev         <= n_prev;
        r_byte         <= n_byte;
        r_rem          <= n_rem;
        r_out          <= n_out;
    end

    `MLD_ASSERT_NOW(a_err_word, i_clk, i_rst_n,
        o_frame.valid && r_out.error_code != ERR_NONE,
        r_out.final_frame && r_out.frame_size == '0 && r_out.repeat_count == '0,
        "error word not final or not zeroed")
    `MLD_ASSERT_NOW(a_mid_word, i_clk, i_rst_n,
        o_frame.valid && !r_out.final_frame,
        r_out.repeat_count == 9'd1 && r_out.error_code == ERR_NONE,
        "non-final word malformed")
    `MLD_ASSERT_NEXT(a_payload_shrinks, i_clk, i_rst_n,
        r_state != S_IDLE,
        r_payload_left <= $past(r_payload_left),
        "payload left grew mid-header")
    `MLD_ASSERT_NEXT(a_div_runs, i_clk, i_rst_n,
        r_state == S_DIV && r_cnt != 5'(DIV_STEPS - 1),
        r_state == S_DIV,
        "divide left early")
    `MLD_ASSERT_NOW(a_more_in_out, i_clk, i_rst_n,
        r_more,
        r_state == S_OUT,
        "pending rest frame outside output state")

endmodule
`default_nettype wire
